// ----- rtl/ptg_pkg.sv -----
// ----------------------------------------------------------------------------
// ptg_pkg
// Shared types, constants and the sine table function for the plucked tone
// generator.
// ----------------------------------------------------------------------------
package ptg_pkg;

   // Stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int TICK_BIT   = 0;

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int NOTE_OUT_W = 3;
   localparam int RSP_PAD_W = RSP_DATA_W - SAMPLE_W - NOTE_OUT_W;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PLUCK_PERIOD,
      CSR_ENV_DECAY,
      CSR_NOTE_STEP,
      CSR_OUTPUT_GAIN
   } csr_index_type;

   typedef struct packed {
      logic [19:0] pluck_period;
      logic [31:0] env_decay;
      logic [2:0]  note_step;
      logic [15:0] output_gain;
   } cfg_type;

   localparam logic [19:0] PLUCK_PERIOD_RESET = 20'd43200;
   localparam logic [31:0] ENV_DECAY_RESET    = 32'd4294768460;
   localparam logic [2:0]  NOTE_STEP_RESET    = 3'd3;
   localparam logic [15:0] OUTPUT_GAIN_RESET  = 16'd22938;

   // Tick queue between front and back
   localparam int TICK_QUEUE_DEPTH = 2;
   localparam int TICK_COUNT_W     = 2;

   // Synthesis constants
   localparam logic [19:0] AGE_MAX = 20'hF_FFFF;
   localparam logic [31:0] ENV_ONE = 32'hFFFF_FFFF;
   localparam logic [15:0] W_H2    = 16'd29491;
   localparam logic [15:0] W_H3    = 16'd14418;
   localparam int NOTE_REDUCE_STEPS = 4;

   localparam int NOTE_TABLE_SIZE = 6;
   localparam logic [15:0] NOTE_CENTIHZ [NOTE_TABLE_SIZE] = '{
      16'd8241, 16'd11000, 16'd14683, 16'd19600, 16'd24694, 16'd32963
   };

   // Sine series
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam int SERIES_TERMS = 7;
   localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };

   // Sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADDR,
      ST_ESQ,
      ST_DECAY,
      ST_RD2,
      ST_RD3,
      ST_H3W,
      ST_H2E,
      ST_H3E,
      ST_SUM,
      ST_ABS,
      ST_TMUL,
      ST_TRND,
      ST_GMUL,
      ST_OUT
   } seq_state_type;

   typedef enum logic [3:0] {
      MUL_PH_D,
      MUL_E_E,
      MUL_E_DECAY,
      MUL_SIN_W2,
      MUL_SIN_W3,
      MUL_H_E,
      MUL_H_E2,
      MUL_T_E,
      MUL_T_G
   } mul_sel_type;

   typedef enum logic [1:0] {
      ROM_FUND,
      ROM_SECOND,
      ROM_THIRD
   } rom_sel_type;

   typedef struct packed {
      logic        mul_en;
      mul_sel_type mul_sel;
      rom_sel_type rom_sel;
      logic        take;
      logic        deliver;
   } seq_ctl_type;

   // Sine of a turn fraction as Q1.15: odd series in Q2.30 over a folded
   // quarter wave, rounded half up, clamped to full scale.
   function automatic logic signed [15:0] sine_of_fraction(input logic [31:0] frac);
      logic [1:0]         quad;
      logic [63:0]        r;
      logic [63:0]        a;
      logic [63:0]        a2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        v;
      quad = frac[31:30];
      r    = {34'd0, frac[29:0]};
      if (quad[0]) begin
         r = 64'h4000_0000 - r;
      end
      a    = (r * TWO_PI_Q30) >> 32;
      a2   = (a * a) >> 30;
      term = a;
      sum  = signed'(a);
      for (int n = 0; n < SERIES_TERMS; n++) begin
         term = ((term * a2) >> 30) / SERIES_DIV[n];
         if (n % 2 == 0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      v = (unsigned'(sum) + 64'd16384) >> 15;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return quad[1] ? -signed'(v[15:0]) : signed'(v[15:0]);
   endfunction

endpackage

// ----- rtl/plucked_tone_generator_core.sv -----
// ----------------------------------------------------------------------------
// plucked_tone_generator_core
// Plucked test-tone source: sine with two harmonics under a decaying envelope.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one tick per transfer; a tick of one asks for the next
//   audio sample, a tick of zero is taken and dropped with no result.
//   rsp_* returns one transfer per sample: Q1.15 sample and note index in
//   tdata, the first-sample-of-pluck flag in tuser.
//   csr_* writes the pluck period, envelope decay, note step and output gain;
//   write them only while no sample is in flight.
// Engine:
//   One sample is in the engine at a time; it takes the next tick only
//   after the last sample is in the result register. The 9 products per
//   sample run through a single shared 32x32 multiplier and the sine
//   table's one read port.
//   Up to two ticks queue ahead of the engine.
// Reset:
//   Registers return to their defaults, the envelope is silent and the age
//   count is at its maximum so the first tick starts a pluck.
// Stall:
//   A result held by rsp_tready low keeps its value; the engine finishes the
//   next sample and then waits for the result register to free.
// ----------------------------------------------------------------------------
module plucked_tone_generator_core #(
   parameter int AUDIO_RATE       = 48000,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int NOTE_COUNT       = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   // Tick stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ptg_pkg::REQ_DATA_W-1:0]    req_tdata,   // [0] tick, [7:1] zero
   // Sample stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ptg_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [15:0] sample, [18:16] note_index,
                                                          // [23:19] zero
   output logic                              rsp_tuser,   // [0] pluck_start
   // Register writes
   input  logic                              csr_wr_en,
   input  logic [ptg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ptg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ptg_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        tick_pending;
   logic        tick_take;
   logic [15:0] sample;
   logic [2:0]  note_index;

   // Register file: take a write on every enabled cycle, ignore other codes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PLUCK_PERIOD: cfg_in.pluck_period = csr_wdata[19:0];
            CSR_ENV_DECAY:    cfg_in.env_decay    = csr_wdata;
            CSR_NOTE_STEP:    cfg_in.note_step    = csr_wdata[2:0];
            CSR_OUTPUT_GAIN:  cfg_in.output_gain  = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pluck_period <= PLUCK_PERIOD_RESET;
         cfg_ff.env_decay    <= ENV_DECAY_RESET;
         cfg_ff.note_step    <= NOTE_STEP_RESET;
         cfg_ff.output_gain  <= OUTPUT_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and filter ticks, hold them for the engine
   ptg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .tick_pending(tick_pending),
      .tick_take   (tick_take)
   );

   // Back: compute one sample per pending tick
   ptg_back #(
      .AUDIO_RATE      (AUDIO_RATE),
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
      .NOTE_COUNT      (NOTE_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .tick_pending(tick_pending),
      .tick_take   (tick_take),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_sample  (sample),
      .rsp_note    (note_index),
      .rsp_pluck   (rsp_tuser)
   );

   // Pack the result transfer
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, note_index, sample};

endmodule

// ----- rtl/ptg_sine_rom.sv -----
// ----------------------------------------------------------------------------
// ptg_sine_rom
// Full-wave Q1.15 sine table, filled at elaboration, with registered read.
// ----------------------------------------------------------------------------
module ptg_sine_rom #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] rd_addr,
   output logic signed [15:0]                  rd_data
);
   import ptg_pkg::*;

   logic signed [15:0] sine_values [SINE_TABLE_DEPTH];
   logic signed [15:0] rd_data_ff;

   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
      localparam logic [63:0] Num  = 64'(k) << 32;
      localparam logic [31:0] Frac = 32'(Num / SINE_TABLE_DEPTH);
      assign sine_values[k] = sine_of_fraction(Frac);
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= sine_values[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ptg_front.sv -----
// ----------------------------------------------------------------------------
// ptg_front
// Request side: take tick transfers, drop zero ticks, count pending ticks.
// ----------------------------------------------------------------------------
module ptg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ptg_pkg::REQ_DATA_W-1:0] req_tdata,   // [0] tick, rest zero fill
   output logic                          tick_pending,
   input  logic                          tick_take
);
   import ptg_pkg::*;

   localparam logic [TICK_COUNT_W-1:0] QueueFull = TICK_COUNT_W'(TICK_QUEUE_DEPTH);

   logic [TICK_COUNT_W-1:0] count_ff;
   logic [TICK_COUNT_W-1:0] count_in;
   logic                    push;

   assign req_tready   = (count_ff != QueueFull);
   assign push         = req_tvalid && req_tready && req_tdata[TICK_BIT];
   assign tick_pending = (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !tick_take) begin
         count_in = count_ff + TICK_COUNT_W'(1);
      end else if (!push && tick_take) begin
         count_in = count_ff - TICK_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/ptg_back.sv -----
// ----------------------------------------------------------------------------
// ptg_back
// Sample engine: sequencer around one shared 32x32 multiplier and the sine
// table, plus the result register.
// ----------------------------------------------------------------------------
module ptg_back #(
   parameter int AUDIO_RATE       = 48000,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int NOTE_COUNT       = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  ptg_pkg::cfg_type cfg,
   input  logic             tick_pending,
   output logic             tick_take,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [15:0]      rsp_sample,
   output logic [2:0]       rsp_note,
   output logic             rsp_pluck
);
   import ptg_pkg::*;

   localparam int AddrW     = $clog2(SINE_TABLE_DEPTH);
   localparam int NoteW     = $clog2(NOTE_COUNT);
   localparam int NoteDepth = 1 << NoteW;
   localparam int NoteSumW  = NoteW + 3;
   localparam logic [AddrW:0]   DepthOne = (AddrW + 1)'(SINE_TABLE_DEPTH);
   localparam logic [AddrW+1:0] DepthTwo = (AddrW + 2)'(2 * SINE_TABLE_DEPTH);
   localparam logic [NoteSumW-1:0] NoteMod = NoteSumW'(NOTE_COUNT);
   localparam logic [63:0] RateDen = 64'(100) * 64'(AUDIO_RATE);

   // Phase increment per note position
   logic [31:0] inc_table [NoteDepth];

   for (genvar p = 0; p < NoteDepth; p++) begin : g_inc
      localparam logic [63:0] Ch  = 64'(NOTE_CENTIHZ[p % NOTE_TABLE_SIZE]);
      localparam logic [31:0] Inc = 32'(((Ch << 32) + RateDen / 2) / RateDen);
      assign inc_table[p] = Inc;
   end

   seq_state_type state_ff, state_in;
   seq_ctl_type   ctl;

   logic [31:0]        ph_ff, ph_in;
   logic [19:0]        age_ff, age_in;
   logic [31:0]        env_ff, env_in;
   logic [NoteW-1:0]   note_ff, note_in;
   logic               pluck_ff, pluck_in;
   logic [63:0]        prod_ff, prod_in;
   logic [AddrW-1:0]   addr1_ff, addr1_in;
   logic [AddrW-1:0]   addr2_ff, addr2_in;
   logic [AddrW-1:0]   addr3_ff, addr3_in;
   logic [31:0]        e2_ff, e2_in;
   logic [31:0]        envn_ff, envn_in;
   logic [31:0]        h_ff, h_in;
   logic [31:0]        t_ff, t_in;
   logic signed [33:0] s_ff, s_in;
   logic               sgn2_ff, sgn2_in;
   logic               sgn3_ff, sgn3_in;
   logic               tsgn_ff, tsgn_in;
   logic               out_valid_ff, out_valid_in;
   logic [15:0]        out_sample_ff, out_sample_in;
   logic [2:0]         out_note_ff, out_note_in;
   logic               out_pluck_ff, out_pluck_in;

   logic [31:0]          mul_a;
   logic [31:0]          mul_b;
   logic [AddrW-1:0]     rom_addr;
   logic signed [15:0]   rom_data;
   logic [15:0]          sin_mag;
   logic                 out_free;
   logic [32:0]          rnd;
   logic [NoteSumW-1:0]  note_sum;
   logic [AddrW:0]       a2_hi;
   logic [AddrW+33:0]    p3;
   logic [AddrW+1:0]     a3_hi;
   logic [AddrW+1:0]     a3_fold;
   logic [33:0]          ph3;

   ptg_sine_rom #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_rom (
      .clock  (clock),
      .rd_addr(rom_addr),
      .rd_data(rom_data)
   );

   assign out_free = !out_valid_ff || rsp_ready;
   assign sin_mag  = rom_data[15] ? 16'(-rom_data) : 16'(rom_data);
   assign rnd      = {1'b0, prod_ff[63:32]} + 33'(prod_ff[31]);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (tick_pending) state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_ESQ;
         ST_ESQ:   state_in = ST_DECAY;
         ST_DECAY: state_in = ST_RD2;
         ST_RD2:   state_in = ST_RD3;
         ST_RD3:   state_in = ST_H3W;
         ST_H3W:   state_in = ST_H2E;
         ST_H2E:   state_in = ST_H3E;
         ST_H3E:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_ABS;
         ST_ABS:   state_in = ST_TMUL;
         ST_TMUL:  state_in = ST_TRND;
         ST_TRND:  state_in = ST_GMUL;
         ST_GMUL:  state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ctl         = '0;
      ctl.mul_sel = MUL_PH_D;
      ctl.rom_sel = ROM_FUND;
      case (state_ff)
         ST_IDLE:  ctl.take = tick_pending;
         ST_ADDR:  begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_PH_D; end
         ST_ESQ:   begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_E_E; end
         ST_DECAY: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_E_DECAY;
            ctl.rom_sel = ROM_FUND;
         end
         ST_RD2:   ctl.rom_sel = ROM_SECOND;
         ST_RD3:   begin
            ctl.rom_sel = ROM_THIRD;
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_SIN_W2;
         end
         ST_H3W:   begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_SIN_W3; end
         ST_H2E:   begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_H_E; end
         ST_H3E:   begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_H_E2; end
         ST_TMUL:  begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_T_E; end
         ST_GMUL:  begin ctl.mul_en = 1'b1; ctl.mul_sel = MUL_T_G; end
         ST_OUT:   ctl.deliver = out_free;
         default:  ctl = '0;
      endcase
   end

   assign tick_take = ctl.take;

   // Shared multiplier operands
   always_comb begin
      case (ctl.mul_sel)
         MUL_PH_D:    begin mul_a = ph_ff;          mul_b = 32'(SINE_TABLE_DEPTH); end
         MUL_E_E:     begin mul_a = env_ff;         mul_b = env_ff; end
         MUL_E_DECAY: begin mul_a = env_ff;         mul_b = cfg.env_decay; end
         MUL_SIN_W2:  begin mul_a = 32'(sin_mag);   mul_b = 32'(W_H2); end
         MUL_SIN_W3:  begin mul_a = 32'(sin_mag);   mul_b = 32'(W_H3); end
         MUL_H_E:     begin mul_a = h_ff;           mul_b = env_ff; end
         MUL_H_E2:    begin mul_a = h_ff;           mul_b = e2_ff; end
         MUL_T_E:     begin mul_a = t_ff;           mul_b = env_ff; end
         MUL_T_G:     begin mul_a = t_ff;           mul_b = 32'(cfg.output_gain); end
         default:     begin mul_a = '0;             mul_b = '0; end
      endcase
   end

   assign prod_in = ctl.mul_en ? ({32'd0, mul_a} * {32'd0, mul_b}) : prod_ff;

   // Table address select
   always_comb begin
      case (ctl.rom_sel)
         ROM_FUND:   rom_addr = addr1_ff;
         ROM_SECOND: rom_addr = addr2_ff;
         ROM_THIRD:  rom_addr = addr3_ff;
         default:    rom_addr = addr1_ff;
      endcase
   end

   // Harmonic addresses from P = phase * depth: fold the wrap of 2x and 3x
   // phase back by whole table lengths.
   assign a2_hi = prod_ff[31 +: AddrW + 1];
   assign p3    = (AddrW + 34)'(prod_ff[AddrW+31:0])
                + (AddrW + 34)'({prod_ff[AddrW+31:0], 1'b0});
   assign a3_hi = p3[32 +: AddrW + 2];
   assign ph3   = {2'b00, ph_ff} + {1'b0, ph_ff, 1'b0};

   always_comb begin
      case (ph3[33:32])
         2'd1:    a3_fold = a3_hi - (AddrW + 2)'(DepthOne);
         2'd2:    a3_fold = a3_hi - DepthTwo;
         default: a3_fold = a3_hi;
      endcase
   end

   // Note advance on a pluck, reduced modulo the note count
   always_comb begin
      note_sum = NoteSumW'(note_ff) + NoteSumW'(cfg.note_step);
      for (int i = 0; i < NOTE_REDUCE_STEPS; i++) begin
         if (note_sum >= NoteMod) begin
            note_sum = note_sum - NoteMod;
         end
      end
   end

   // Datapath next values
   always_comb begin
      ph_in         = ph_ff;
      age_in        = age_ff;
      env_in        = env_ff;
      note_in       = note_ff;
      pluck_in      = pluck_ff;
      addr1_in      = addr1_ff;
      addr2_in      = addr2_ff;
      addr3_in      = addr3_ff;
      e2_in         = e2_ff;
      envn_in       = envn_ff;
      h_in          = h_ff;
      t_in          = t_ff;
      s_in          = s_ff;
      sgn2_in       = sgn2_ff;
      sgn3_in       = sgn3_ff;
      tsgn_in       = tsgn_ff;
      out_sample_in = out_sample_ff;
      out_note_in   = out_note_ff;
      out_pluck_in  = out_pluck_ff;

      // Retrigger when the age reaches the period
      if (ctl.take) begin
         pluck_in = 1'b0;
         if (age_ff >= cfg.pluck_period) begin
            age_in   = '0;
            ph_in    = '0;
            env_in   = ENV_ONE;
            note_in  = NoteW'(note_sum);
            pluck_in = 1'b1;
         end
      end

      case (state_ff)
         ST_ESQ: begin
            addr1_in = prod_ff[32 +: AddrW];
            addr2_in = AddrW'(ph_ff[31] ? (a2_hi - DepthOne) : a2_hi);
            addr3_in = AddrW'(a3_fold);
         end
         ST_DECAY: e2_in = prod_ff[63:32];
         ST_RD2: begin
            envn_in = prod_ff[63:32];
            s_in    = {{2{rom_data[15]}}, rom_data, 16'd0};
         end
         ST_RD3:  sgn2_in = rom_data[15];
         ST_H3W: begin
            sgn3_in = rom_data[15];
            h_in    = prod_ff[31:0];
         end
         ST_H2E:  h_in = prod_ff[31:0];
         ST_H3E:  s_in = sgn2_ff ? (s_ff - signed'(34'(rnd))) : (s_ff + signed'(34'(rnd)));
         ST_SUM:  s_in = sgn3_ff ? (s_ff - signed'(34'(rnd))) : (s_ff + signed'(34'(rnd)));
         ST_ABS: begin
            tsgn_in = s_ff[33];
            t_in    = s_ff[33] ? 32'(-s_ff) : 32'(s_ff);
         end
         ST_TRND: t_in = rnd[31:0];
         ST_OUT: begin
            if (ctl.deliver) begin
               // Saturate to Q1.15
               if (tsgn_ff) begin
                  out_sample_in = (rnd > 33'd32768) ? 16'h8000 : 16'(-rnd);
               end else begin
                  out_sample_in = (rnd > 33'd32767) ? 16'h7FFF : rnd[15:0];
               end
               out_note_in  = 3'(note_ff);
               out_pluck_in = pluck_ff;
               ph_in        = ph_ff + inc_table[note_ff];
               age_in       = (age_ff != AGE_MAX) ? (age_ff + 20'd1) : age_ff;
               env_in       = envn_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctl.deliver) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= '0;
         age_ff       <= AGE_MAX;
         env_ff       <= '0;
         note_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         age_ff       <= age_in;
         env_ff       <= env_in;
         note_ff      <= note_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pluck_ff      <= pluck_in;
      prod_ff       <= prod_in;
      addr1_ff      <= addr1_in;
      addr2_ff      <= addr2_in;
      addr3_ff      <= addr3_in;
      e2_ff         <= e2_in;
      envn_ff       <= envn_in;
      h_ff          <= h_in;
      t_ff          <= t_in;
      s_ff          <= s_in;
      sgn2_ff       <= sgn2_in;
      sgn3_ff       <= sgn3_in;
      tsgn_ff       <= tsgn_in;
      out_sample_ff <= out_sample_in;
      out_note_ff   <= out_note_in;
      out_pluck_ff  <= out_pluck_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_note   = out_note_ff;
   assign rsp_pluck  = out_pluck_ff;

endmodule
